FILE: src/cpfb_pkg.sv
// Shared types, register indexes and constants for the clip plane unit.
package cpfb_pkg;

  // Default width of the box coordinates that are actually used.
  localparam int unsigned CoordWidthDefault = 32;

  // Depth of the root and quotient cell rows.
  localparam int unsigned SqrtCells = 32;
  localparam int unsigned DivCells  = 32;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ENABLED   = 3'd0;
  localparam logic [2:0] CFG_AXIS_MODE = 3'd1;
  localparam logic [2:0] CFG_REF_MODE  = 3'd2;
  localparam logic [2:0] CFG_OFFSET    = 3'd3;
  localparam logic [2:0] CFG_FLIP      = 3'd4;
  localparam logic [2:0] CFG_CUSTOM_X  = 3'd5;
  localparam logic [2:0] CFG_CUSTOM_Y  = 3'd6;
  localparam logic [2:0] CFG_CUSTOM_Z  = 3'd7;

  // Normal source codes.
  localparam logic [2:0] AXIS_X      = 3'd0;
  localparam logic [2:0] AXIS_Y      = 3'd1;
  localparam logic [2:0] AXIS_Z      = 3'd2;
  localparam logic [2:0] AXIS_VIEW   = 3'd3;
  localparam logic [2:0] AXIS_CUSTOM = 3'd4;

  // Reference point codes.
  localparam logic [1:0] REF_ORIGIN = 2'd0;
  localparam logic [1:0] REF_CENTER = 2'd1;
  localparam logic [1:0] REF_MIN    = 2'd2;
  localparam logic [1:0] REF_MAX    = 2'd3;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic signed [31:0] view_dir_x;
    logic signed [31:0] view_dir_y;
    logic signed [31:0] view_dir_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] plane_a;
    logic signed [31:0] plane_b;
    logic signed [31:0] plane_c;
    logic signed [31:0] plane_d;
    logic               plane_valid;
  } out_t;

  // Side data that travels with a box through the cell rows.
  typedef struct packed {
    logic             ok;
    logic [2:0]       neg;
    logic             sh;
    logic [2:0][29:0] un;
    logic [2:0][32:0] p2;
    logic [32:0]      diag;
  } ctx_t;

  // One square root lane: radicand bits still to consume, remainder, root.
  typedef struct packed {
    logic [63:0] rad;
    logic [32:0] rem;
    logic [31:0] root;
  } sq_t;

  // One divide lane: dividend bits still to consume, remainder, quotient.
  typedef struct packed {
    logic [31:0] num;
    logic [31:0] rem;
    logic [31:0] quo;
  } dv_t;

  typedef struct packed {
    logic [31:0]     divisor;
    logic [2:0]      unused_pad;
    dv_t [2:0]       lane;
  } div_t;

endpackage

FILE: src/cpfb_sqrt_cell.sv
// One cell of the square root row: resolves one root bit on two lanes.
module cpfb_sqrt_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  cpfb_pkg::sq_t [1:0]  lane_i,
  input  cpfb_pkg::ctx_t       ctx_i,
  output logic                 valid_o,
  output cpfb_pkg::sq_t [1:0]  lane_o,
  output cpfb_pkg::ctx_t       ctx_o
);

  logic                valid_q;
  cpfb_pkg::sq_t [1:0] lane_q, lane_d;
  cpfb_pkg::ctx_t      ctx_q;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    logic [34:0] t;
    logic [34:0] trial;
    logic        ge;
    for (int l = 0; l < 2; l++) begin
      t     = {lane_i[l].rem, lane_i[l].rad[63:62]};
      trial = {1'b0, lane_i[l].root, 2'b01};
      ge    = (t >= trial);
      lane_d[l].rem  = ge ? 33'(t - trial) : t[32:0];
      lane_d[l].root = {lane_i[l].root[30:0], ge};
      lane_d[l].rad  = {lane_i[l].rad[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
      ctx_q  <= ctx_i;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;
  assign ctx_o   = ctx_q;

endmodule

FILE: src/cpfb_div_cell.sv
// One cell of the divide row: resolves one quotient bit on three lanes.
module cpfb_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cpfb_pkg::div_t  div_i,
  input  cpfb_pkg::ctx_t  ctx_i,
  output logic            valid_o,
  output cpfb_pkg::div_t  div_o,
  output cpfb_pkg::ctx_t  ctx_o
);

  logic           valid_q;
  cpfb_pkg::div_t div_q, div_d;
  cpfb_pkg::ctx_t ctx_q;

  // Shift in one dividend bit and subtract the divisor when it fits.
  always_comb begin
    logic [32:0] t;
    logic        ge;
    div_d = div_i;
    for (int l = 0; l < 3; l++) begin
      t  = {div_i.lane[l].rem, div_i.lane[l].num[31]};
      ge = (t >= {1'b0, div_i.divisor});
      div_d.lane[l].rem = ge ? 32'(t - {1'b0, div_i.divisor}) : t[31:0];
      div_d.lane[l].num = {div_i.lane[l].num[30:0], 1'b0};
      div_d.lane[l].quo = {div_i.lane[l].quo[30:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
      ctx_q <= ctx_i;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;
  assign ctx_o   = ctx_q;

endmodule

FILE: src/clip_plane_from_bounds_unit.sv
// Top level of the clip plane unit: configuration, front stages, cell rows, back stages.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  in_i   (box corners, view direction)
//   out      output     out_valid_o/out_stall_i out_o (plane a, b, c, d, valid)
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// One beat is taken per cycle unless a stall on the output holds the row.
// Most of the stages are the 32-cell square root row and the 32-cell divide row.
// Reset clears the valid bits of every stage and loads the register defaults.
// A stall on the output holds the whole row; input is taken whenever the
// output register is empty or being read.
module clip_plane_from_bounds_unit #(
  parameter int unsigned COORD_WIDTH = cpfb_pkg::CoordWidthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cpfb_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cpfb_pkg::out_t out_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i
);

  localparam int unsigned CwUsed = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam int unsigned ExtSh  = 32 - CwUsed;

  // Configuration registers.
  logic                enabled_q;
  logic [2:0]          axis_q;
  logic [1:0]          ref_q;
  logic signed [23:0]  offset_q;
  logic                flip_q;
  logic signed [31:0]  cust_x_q, cust_y_q, cust_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      axis_q    <= cpfb_pkg::AXIS_X;
      ref_q     <= cpfb_pkg::REF_ORIGIN;
      offset_q  <= '0;
      flip_q    <= 1'b0;
      cust_x_q  <= '0;
      cust_y_q  <= '0;
      cust_z_q  <= cpfb_pkg::ONE_Q16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cpfb_pkg::CFG_ENABLED:   enabled_q <= cfg_data_i[0];
        cpfb_pkg::CFG_AXIS_MODE: axis_q    <= cfg_data_i[2:0];
        cpfb_pkg::CFG_REF_MODE:  ref_q     <= cfg_data_i[1:0];
        cpfb_pkg::CFG_OFFSET:    offset_q  <= cfg_data_i[23:0];
        cpfb_pkg::CFG_FLIP:      flip_q    <= cfg_data_i[0];
        cpfb_pkg::CFG_CUSTOM_X:  cust_x_q  <= cfg_data_i;
        cpfb_pkg::CFG_CUSTOM_Y:  cust_y_q  <= cfg_data_i;
        cpfb_pkg::CFG_CUSTOM_Z:  cust_z_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole row moves unless a finished beat is held at the output.
  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Front stage: extend corners, pick and scale the normal, box extents, reference point.
  cpfb_pkg::ctx_t     f1_ctx_d, f1_ctx_q;
  logic [2:0][30:0]   f1_ue_d, f1_ue_q;
  logic               f1_valid_q;

  always_comb begin
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic signed [31:0] src [3];
    logic [31:0]        us [3];
    logic [31:0]        ue [3];
    logic signed [32:0] e;
    logic [31:0]        m, me;
    logic [4:0]         p;
    logic               axis_ok;
    lo[0] = $signed(in_i.box_min_x << ExtSh) >>> ExtSh;
    lo[1] = $signed(in_i.box_min_y << ExtSh) >>> ExtSh;
    lo[2] = $signed(in_i.box_min_z << ExtSh) >>> ExtSh;
    hi[0] = $signed(in_i.box_max_x << ExtSh) >>> ExtSh;
    hi[1] = $signed(in_i.box_max_y << ExtSh) >>> ExtSh;
    hi[2] = $signed(in_i.box_max_z << ExtSh) >>> ExtSh;
    axis_ok = 1'b1;
    src[0] = '0;
    src[1] = '0;
    src[2] = '0;
    unique case (axis_q)
      cpfb_pkg::AXIS_X: src[0] = cpfb_pkg::ONE_Q16;
      cpfb_pkg::AXIS_Y: src[1] = cpfb_pkg::ONE_Q16;
      cpfb_pkg::AXIS_Z: src[2] = cpfb_pkg::ONE_Q16;
      cpfb_pkg::AXIS_VIEW: begin
        src[0] = in_i.view_dir_x;
        src[1] = in_i.view_dir_y;
        src[2] = in_i.view_dir_z;
      end
      cpfb_pkg::AXIS_CUSTOM: begin
        src[0] = cust_x_q;
        src[1] = cust_y_q;
        src[2] = cust_z_q;
      end
      default: axis_ok = 1'b0;
    endcase
    m  = '0;
    me = '0;
    f1_ctx_d = '0;
    for (int i = 0; i < 3; i++) begin
      us[i] = src[i][31] ? 32'(-{src[i][31], src[i]}) : src[i];
      e     = 33'(hi[i]) - 33'(lo[i]);
      ue[i] = e[32] ? 32'(-e) : e[31:0];
      if (us[i] > m) m = us[i];
      if (ue[i] > me) me = ue[i];
      f1_ctx_d.neg[i] = src[i][31];
      unique case (ref_q)
        cpfb_pkg::REF_CENTER: f1_ctx_d.p2[i] = 33'(lo[i]) + 33'(hi[i]);
        cpfb_pkg::REF_MIN:    f1_ctx_d.p2[i] = {lo[i], 1'b0};
        cpfb_pkg::REF_MAX:    f1_ctx_d.p2[i] = {hi[i], 1'b0};
        default:              f1_ctx_d.p2[i] = '0;
      endcase
    end
    // Leading one of the largest normal component.
    p = '0;
    for (int k = 0; k < 32; k++) begin
      if (m[k]) p = 5'(k);
    end
    for (int i = 0; i < 3; i++) begin
      if (p < 5'd29) f1_ctx_d.un[i] = 30'(us[i] << (5'd29 - p));
      else           f1_ctx_d.un[i] = 30'(us[i] >> (p - 5'd29));
      f1_ue_d[i] = me[31] ? 31'(ue[i] >> 1) : ue[i][30:0];
    end
    f1_ctx_d.sh = me[31];
    f1_ctx_d.ok = enabled_q && axis_ok && (m != '0) && (me != '0);
  end

  // Squares of the scaled normal and of the extents.
  cpfb_pkg::ctx_t     f2_ctx_q;
  logic [2:0][59:0]   f2_sn_q;
  logic [2:0][61:0]   f2_se_q;
  logic               f2_valid_q;

  // Sums of squares feed the square root row.
  cpfb_pkg::sq_t [1:0] f3_lane_q;
  cpfb_pkg::ctx_t      f3_ctx_q;
  logic                f3_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
      f3_valid_q <= 1'b0;
    end else if (en) begin
      f1_valid_q <= in_valid_i;
      f2_valid_q <= f1_valid_q;
      f3_valid_q <= f2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_ctx_q <= f1_ctx_d;
      f1_ue_q  <= f1_ue_d;
      f2_ctx_q <= f1_ctx_q;
      for (int i = 0; i < 3; i++) begin
        f2_sn_q[i] <= 60'(f1_ctx_q.un[i]) * 60'(f1_ctx_q.un[i]);
        f2_se_q[i] <= 62'(f1_ue_q[i]) * 62'(f1_ue_q[i]);
      end
      f3_ctx_q          <= f2_ctx_q;
      f3_lane_q[0].rad  <= {62'(f2_sn_q[0]) + 62'(f2_sn_q[1]) + 62'(f2_sn_q[2]), 2'b00};
      f3_lane_q[0].rem  <= '0;
      f3_lane_q[0].root <= '0;
      f3_lane_q[1].rad  <= 64'(f2_se_q[0]) + 64'(f2_se_q[1]) + 64'(f2_se_q[2]);
      f3_lane_q[1].rem  <= '0;
      f3_lane_q[1].root <= '0;
    end
  end

  // Square root row: normal length on lane 0, box diagonal on lane 1.
  logic                sq_valid [cpfb_pkg::SqrtCells+1];
  cpfb_pkg::sq_t [1:0] sq_lane  [cpfb_pkg::SqrtCells+1];
  cpfb_pkg::ctx_t      sq_ctx   [cpfb_pkg::SqrtCells+1];

  assign sq_valid[0] = f3_valid_q;
  assign sq_lane[0]  = f3_lane_q;
  assign sq_ctx[0]   = f3_ctx_q;

  for (genvar g = 0; g < cpfb_pkg::SqrtCells; g++) begin : g_sqrt
    cpfb_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[g]),
      .lane_i  (sq_lane[g]),
      .ctx_i   (sq_ctx[g]),
      .valid_o (sq_valid[g+1]),
      .lane_o  (sq_lane[g+1]),
      .ctx_o   (sq_ctx[g+1])
    );
  end

  // Set up the three divides and finish the diagonal.
  cpfb_pkg::div_t pr_div_q;
  cpfb_pkg::ctx_t pr_ctx_q;
  logic           pr_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_valid_q <= 1'b0;
    end else if (en) begin
      pr_valid_q <= sq_valid[cpfb_pkg::SqrtCells];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [31:0]    len;
    logic [31:0]    rd;
    logic [61:0]    num;
    cpfb_pkg::ctx_t ctx;
    if (en) begin
      len = sq_lane[cpfb_pkg::SqrtCells][0].root;
      rd  = sq_lane[cpfb_pkg::SqrtCells][1].root;
      ctx = sq_ctx[cpfb_pkg::SqrtCells];
      ctx.diag = ctx.sh ? {rd, 1'b0} : {1'b0, rd};
      pr_ctx_q            <= ctx;
      pr_div_q.divisor    <= len;
      pr_div_q.unused_pad <= '0;
      for (int i = 0; i < 3; i++) begin
        num = {sq_ctx[cpfb_pkg::SqrtCells].un[i], 32'd0} >> 1;
        num = num + 62'(len >> 1);
        pr_div_q.lane[i].rem <= {2'b00, num[61:32]};
        pr_div_q.lane[i].num <= num[31:0];
        pr_div_q.lane[i].quo <= '0;
      end
    end
  end

  // Divide row: one quotient bit per cell on all three components.
  logic           dv_valid [cpfb_pkg::DivCells+1];
  cpfb_pkg::div_t dv_div   [cpfb_pkg::DivCells+1];
  cpfb_pkg::ctx_t dv_ctx   [cpfb_pkg::DivCells+1];

  assign dv_valid[0] = pr_valid_q;
  assign dv_div[0]   = pr_div_q;
  assign dv_ctx[0]   = pr_ctx_q;

  for (genvar g = 0; g < cpfb_pkg::DivCells; g++) begin : g_div
    cpfb_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[g]),
      .div_i   (dv_div[g]),
      .ctx_i   (dv_ctx[g]),
      .valid_o (dv_valid[g+1]),
      .div_o   (dv_div[g+1]),
      .ctx_o   (dv_ctx[g+1])
    );
  end

  // Back stage one: signed unit normal and all products.
  logic                      b1_valid_q, b1_ok_q;
  logic signed [2:0][31:0]   b1_n_q;
  logic signed [2:0][48:0]   b1_hp_q, b1_lp_q;
  logic signed [57:0]        b1_tp_q;

  // Back stage two: sums and the rounded offset term.
  logic                      b2_valid_q, b2_ok_q;
  logic signed [2:0][31:0]   b2_n_q;
  logic signed [50:0]        b2_h_q, b2_l_q;
  logic signed [41:0]        b2_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      b1_valid_q  <= dv_valid[cpfb_pkg::DivCells];
      b2_valid_q  <= b1_valid_q;
      out_valid_q <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [31:0]        q;
    logic [30:0]        qc;
    logic signed [31:0] n;
    logic signed [32:0] p2;
    logic signed [16:0] ph;
    logic signed [16:0] pl;
    if (en) begin
      b1_ok_q <= dv_ctx[cpfb_pkg::DivCells].ok;
      for (int i = 0; i < 3; i++) begin
        q  = dv_div[cpfb_pkg::DivCells].lane[i].quo;
        qc = (q > 32'h4000_0000) ? 31'h4000_0000 : q[30:0];
        n  = dv_ctx[cpfb_pkg::DivCells].neg[i] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        p2 = $signed(dv_ctx[cpfb_pkg::DivCells].p2[i]);
        ph = p2[32:16];
        pl = $signed({1'b0, p2[15:0]});
        b1_n_q[i]  <= n;
        b1_hp_q[i] <= 49'(n) * 49'(ph);
        b1_lp_q[i] <= 49'(n) * 49'(pl);
      end
      b1_tp_q <= 58'(offset_q) * $signed({25'd0, dv_ctx[cpfb_pkg::DivCells].diag});

      // Each product is read as unsigned from the packed array, so it is cast back to signed.
      b2_ok_q <= b1_ok_q;
      b2_n_q  <= b1_n_q;
      b2_h_q  <= 51'($signed(b1_hp_q[0])) + 51'($signed(b1_hp_q[1]))
               + 51'($signed(b1_hp_q[2]));
      b2_l_q  <= 51'($signed(b1_lp_q[0])) + 51'($signed(b1_lp_q[1]))
               + 51'($signed(b1_lp_q[2]));
      b2_t_q  <= 42'((b1_tp_q + 58'sd32768) >>> 16);
    end
  end

  // Output register: rounded dot product, d, side flip and saturation.
  cpfb_pkg::out_t out_q;

  always_ff @(posedge clk_i) begin
    logic signed [51:0] rl;
    logic signed [47:0] dot;
    logic signed [47:0] d;
    if (en) begin
      rl  = $signed({21'd0, b2_h_q[14:0], 16'd0}) + 52'(b2_l_q) + 52'sd1073741824;
      dot = 48'(b2_h_q >>> 15) + 48'(rl >>> 31);
      d   = -dot - 48'(b2_t_q);
      if (flip_q) d = -d;
      if (!b2_ok_q) begin
        out_q <= '0;
      end else begin
        out_q.plane_a <= flip_q ? -b2_n_q[0] : b2_n_q[0];
        out_q.plane_b <= flip_q ? -b2_n_q[1] : b2_n_q[1];
        out_q.plane_c <= flip_q ? -b2_n_q[2] : b2_n_q[2];
        if (d > 48'sd2147483647)       out_q.plane_d <= 32'sh7fff_ffff;
        else if (d < -48'sd2147483648) out_q.plane_d <= 32'sh8000_0000;
        else                           out_q.plane_d <= d[31:0];
        out_q.plane_valid <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
